// ===== hw/rtl/asn1_time_string_to_epoch_assert.svh =====
// Assertion helpers for the time string converter.
`ifndef ASN1_TIME_STRING_TO_EPOCH_ASSERT_SVH
`define ASN1_TIME_STRING_TO_EPOCH_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASN1T_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASN1T_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASN1T_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASN1T_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/asn1t_pkg.sv =====
`timescale 1ns / 1ps
package asn1t_pkg;

   localparam int MAX_CHARS_DEF = 32;
   localparam int HEAD_LEN      = 14;
   localparam int ZONE_LEN      = 4;
   localparam int NUM_TERM      = 3;

   localparam logic [1:0] TERM_Z     = 2'd0;
   localparam logic [1:0] TERM_PLUS  = 2'd1;
   localparam logic [1:0] TERM_MINUS = 2'd2;

   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [NUM_TERM-1:0][7:0] TERM_CODES = {CHAR_MINUS, CHAR_PLUS, CHAR_Z};

   localparam int EPOCH_W = 39;
   localparam int ACC_W   = 40;
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
   localparam int OFFS_W  = 22;
   localparam int YEAR_W  = 14;

   localparam int RECIP_LSB = 19;
   localparam logic [MUL_B_W-1:0] RECIP_100     = 17'd5243;
   localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 17'd365;
   localparam logic [MUL_B_W-1:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [MUL_B_W-1:0] SEC_PER_HOUR  = 17'd3600;
   localparam logic [MUL_B_W-1:0] SEC_PER_MIN   = 17'd60;
   localparam logic [MUL_B_W-1:0] SEC_ONE       = 17'd1;
   // days from 0000-03-01 to 1970-01-01, plus one for the 1-based day of month
   localparam logic [OFFS_W-1:0] DAY_BIAS = 22'd719469;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_Q100,
      ST_Q400,
      ST_LDQ,
      ST_DAYS,
      ST_SCALE,
      ST_HR,
      ST_MN,
      ST_SEC,
      ST_ZH,
      ST_ZM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                                 ovf;
      logic                                 gen;
      logic [HEAD_LEN-1:0]                  hd_ok;
      logic [HEAD_LEN-1:0][3:0]             hd_val;
      logic [NUM_TERM-1:0]                  t_seen;
      logic [NUM_TERM-1:0]                  t_at12;
      logic [NUM_TERM-1:0]                  t_at14;
      logic [NUM_TERM-1:0][ZONE_LEN-1:0]    z_ok;
      logic [NUM_TERM-1:0][ZONE_LEN-1:0][3:0] z_val;
   } cap_type;

   typedef struct packed {
      logic              ok;
      logic              zsub;
      logic [YEAR_W-1:0] yp;
      logic [8:0]        doy;
      logic [6:0]        day;
      logic [6:0]        hr;
      logic [6:0]        mn;
      logic [6:0]        sec;
      logic [6:0]        zh;
      logic [6:0]        zm;
   } dec_type;

   typedef struct packed {
      logic                      en;
      logic                      use_acc;
      logic signed [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0]        b;
      logic signed [OFFS_W-1:0]  c;
   } mac_cmd_type;

   function automatic logic [6:0] two_digit(input logic [3:0] hi, input logic [3:0] lo);
      two_digit = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
   endfunction

   // days from March 1 to the first of the month, March-based year
   function automatic logic [8:0] doy_of_month(input logic [3:0] mon);
      case (mon)
         4'd3:    doy_of_month = 9'd0;
         4'd4:    doy_of_month = 9'd31;
         4'd5:    doy_of_month = 9'd61;
         4'd6:    doy_of_month = 9'd92;
         4'd7:    doy_of_month = 9'd122;
         4'd8:    doy_of_month = 9'd153;
         4'd9:    doy_of_month = 9'd184;
         4'd10:   doy_of_month = 9'd214;
         4'd11:   doy_of_month = 9'd245;
         4'd12:   doy_of_month = 9'd275;
         4'd1:    doy_of_month = 9'd306;
         4'd2:    doy_of_month = 9'd337;
         default: doy_of_month = 9'd0;
      endcase
   endfunction

endpackage

// ===== hw/rtl/asn1t_capture.sv =====
`timescale 1ns / 1ps
module asn1t_capture #(
   parameter int MAX_CHARS = asn1t_pkg::MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              xfer,
   input  logic              clear,
   input  logic [7:0]        char_code,
   input  logic              generalized,
   output asn1t_pkg::cap_type cap
);
   import asn1t_pkg::*;

   localparam int CNT_W = $clog2(MAX_CHARS + 1);
   localparam int POS_W = $clog2(MAX_CHARS);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             gen_ff;
   logic [HEAD_LEN-1:0]      hd_dig_ff;
   logic [HEAD_LEN-1:0][3:0] hd_val_ff;
   logic [NUM_TERM-1:0]      seen_ff, seen_in;
   logic [NUM_TERM-1:0][POS_W-1:0] pos_ff;
   logic [NUM_TERM-1:0][POS_W-1:0] term_gap;
   logic [NUM_TERM-1:0][ZONE_LEN-1:0] z_ok_ff, z_ok_in;
   logic [NUM_TERM-1:0][ZONE_LEN-1:0][3:0] z_val_ff;

   logic             store;
   logic             is_digit;
   logic [POS_W-1:0] wpos;

   assign store    = xfer && (cnt_ff < CNT_W'(MAX_CHARS));
   assign wpos     = cnt_ff[POS_W-1:0];
   assign is_digit = char_code inside {[CHAR_0:CHAR_9]};

   always_comb begin
      for (int t = 0; t < NUM_TERM; t++) begin
         term_gap[t] = wpos - pos_ff[t];
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      seen_in = seen_ff;
      z_ok_in = z_ok_ff;
      if (clear) begin
         cnt_in  = '0;
         ovf_in  = 1'b0;
         seen_in = '0;
         z_ok_in = '0;
      end else if (xfer) begin
         if (store) begin
            cnt_in = cnt_ff + 1'b1;
            for (int t = 0; t < NUM_TERM; t++) begin
               if (!seen_ff[t] && char_code == TERM_CODES[t]) begin
                  seen_in[t] = 1'b1;
               end
               for (int k = 0; k < ZONE_LEN; k++) begin
                  if (seen_ff[t] && term_gap[t] == POS_W'(k + 1)) begin
                     z_ok_in[t][k] = is_digit;
                  end
               end
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         seen_ff <= '0;
         z_ok_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         seen_ff <= seen_in;
         z_ok_ff <= z_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         gen_ff <= generalized;
      end
      for (int i = 0; i < HEAD_LEN; i++) begin
         if (store && wpos == POS_W'(i)) begin
            hd_val_ff[i] <= char_code[3:0];
            hd_dig_ff[i] <= is_digit;
         end
      end
      for (int t = 0; t < NUM_TERM; t++) begin
         if (store && !seen_ff[t] && char_code == TERM_CODES[t]) begin
            pos_ff[t] <= wpos;
         end
         for (int k = 0; k < ZONE_LEN; k++) begin
            if (store && seen_ff[t] && term_gap[t] == POS_W'(k + 1)) begin
               z_val_ff[t][k] <= char_code[3:0];
            end
         end
      end
   end

   always_comb begin
      cap.ovf    = ovf_ff;
      cap.gen    = gen_ff;
      cap.hd_val = hd_val_ff;
      for (int i = 0; i < HEAD_LEN; i++) begin
         cap.hd_ok[i] = hd_dig_ff[i] && (cnt_ff > CNT_W'(i));
      end
      cap.t_seen = seen_ff;
      for (int t = 0; t < NUM_TERM; t++) begin
         cap.t_at12[t] = pos_ff[t] == POS_W'(12);
         cap.t_at14[t] = pos_ff[t] == POS_W'(14);
      end
      cap.z_ok  = z_ok_ff;
      cap.z_val = z_val_ff;
   end

endmodule

// ===== hw/rtl/asn1t_decode.sv =====
`timescale 1ns / 1ps
module asn1t_decode (
   input  asn1t_pkg::cap_type cap,
   output asn1t_pkg::dec_type dec
);
   import asn1t_pkg::*;

   logic [1:0]        sel;
   logic              term_ok;
   logic              zone_ok;
   logic              head_ok;
   logic              sec_here;
   logic              sec_ok;
   logic              year_ok;
   logic              mon_ok;
   logic [6:0]        yh;
   logic [6:0]        yl;
   logic [6:0]        mon;
   logic [6:0]        sec;
   logic [YEAR_W-1:0] year;
   logic [YEAR_W-1:0] full;

   always_comb begin
      term_ok = |cap.t_seen;
      if (cap.t_seen[TERM_Z]) begin
         sel = TERM_Z;
      end else if (cap.t_seen[TERM_PLUS]) begin
         sel = TERM_PLUS;
      end else begin
         sel = TERM_MINUS;
      end
      zone_ok = (sel == TERM_Z) || (&cap.z_ok[sel]);

      yh = two_digit(cap.hd_val[0], cap.hd_val[1]);
      yl = two_digit(cap.hd_val[2], cap.hd_val[3]);
      dec = '0;
      if (cap.gen) begin
         head_ok  = &cap.hd_ok[11:0];
         year     = {1'b0, yh, 6'b000000} + {2'b00, yh, 5'b00000}
                    + {5'b00000, yh, 2'b00} + {7'b0000000, yl};
         mon      = two_digit(cap.hd_val[4], cap.hd_val[5]);
         dec.day  = two_digit(cap.hd_val[6], cap.hd_val[7]);
         dec.hr   = two_digit(cap.hd_val[8], cap.hd_val[9]);
         dec.mn   = two_digit(cap.hd_val[10], cap.hd_val[11]);
         sec_here = cap.t_at14[sel];
         sec      = two_digit(cap.hd_val[12], cap.hd_val[13]);
         sec_ok   = cap.hd_ok[12] && cap.hd_ok[13];
      end else begin
         head_ok  = &cap.hd_ok[9:0];
         year     = YEAR_W'(yh);
         mon      = two_digit(cap.hd_val[2], cap.hd_val[3]);
         dec.day  = two_digit(cap.hd_val[4], cap.hd_val[5]);
         dec.hr   = two_digit(cap.hd_val[6], cap.hd_val[7]);
         dec.mn   = two_digit(cap.hd_val[8], cap.hd_val[9]);
         sec_here = cap.t_at12[sel];
         sec      = two_digit(cap.hd_val[10], cap.hd_val[11]);
         sec_ok   = cap.hd_ok[10] && cap.hd_ok[11];
      end

      year_ok = 1'b1;
      if (year >= YEAR_W'(1900)) begin
         full = year;
      end else if (year >= YEAR_W'(100)) begin
         full    = year;
         year_ok = 1'b0;
      end else if (year < YEAR_W'(50)) begin
         full = year + YEAR_W'(2000);
      end else begin
         full = year + YEAR_W'(1900);
      end

      mon_ok = (mon >= 7'd1) && (mon <= 7'd12);

      dec.ok   = !cap.ovf && term_ok && zone_ok && head_ok && (!sec_here || sec_ok)
                 && year_ok && mon_ok;
      dec.zsub = (sel == TERM_PLUS);
      dec.sec  = sec_here ? sec : 7'd0;
      dec.yp   = (mon <= 7'd2) ? full - 1'b1 : full;
      dec.doy  = doy_of_month(mon[3:0]);
      if (sel != TERM_Z) begin
         dec.zh = two_digit(cap.z_val[sel][0], cap.z_val[sel][1]);
         dec.zm = two_digit(cap.z_val[sel][2], cap.z_val[sel][3]);
      end
   end

endmodule

// ===== hw/rtl/asn1t_mac.sv =====
`timescale 1ns / 1ps
module asn1t_mac (
   input  logic                            clock,
   input  asn1t_pkg::mac_cmd_type          cmd,
   output logic signed [asn1t_pkg::ACC_W-1:0] acc
);
   import asn1t_pkg::*;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  base;

   always_comb begin
      prod   = cmd.a * $signed({1'b0, cmd.b});
      base   = cmd.use_acc ? acc_ff : ACC_W'(cmd.c);
      acc_in = base + $signed(prod[ACC_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== hw/rtl/asn1_time_string_to_epoch.sv =====
// ASN.1 UTCTime / GeneralizedTime string to seconds since 1970 UTC.
// Input channel (req_*): one character per transfer; req_tlast marks the
// final character of a string, req_tuser gives the form (0 two-digit year,
// 1 four-digit year) and is taken from the final character.
// Result channel (rsp_*): one transfer per string, 39-bit signed seconds and
// a valid flag; seconds are zero when the string does not parse.
// Characters are taken one per cycle while the converter is idle. After the
// final character the block takes one step to check the fields, nine
// steps of the shared multiply-accumulate unit (two reciprocal divides by
// 100, day count, scale to seconds, time and zone terms), one to pick up the
// second quotient and one to load the result register. A string that fails
// the check goes straight to the load. req_tready stays low during the check,
// the calendar steps and the load. A stalled result is held in the output
// register; further characters are still taken, but the next string's
// result waits in the converter, with req_tready low, until the held result
// has been transferred.
// Reset clears the character count, the terminator tracking and the
// result valid flag; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`include "asn1_time_string_to_epoch_assert.svh"
module asn1_time_string_to_epoch #(
   parameter int MAX_CHARS = asn1t_pkg::MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   input  logic        req_tuser,   // [0] generalized
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [38:0] epoch_seconds, [39] valid_res
);
   import asn1t_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [EPOCH_W:0] rsp_data_ff;
   logic      rsp_load;
   logic      req_xfer;
   logic      clear;

   cap_type     cap;
   dec_type     dec;
   dec_type     dec_ff;
   mac_cmd_type cmd;
   logic signed [ACC_W-1:0] acc;
   logic [6:0]        q100_ff;
   logic [4:0]        q400_ff;
   logic [OFFS_W-1:0] days_offs;
   logic [YEAR_W-3:0] q4;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   asn1t_capture #(.MAX_CHARS(MAX_CHARS)) u_capture (
      .clock       (clock),
      .reset       (reset),
      .xfer        (req_xfer),
      .clear       (clear),
      .char_code   (req_tdata),
      .generalized (req_tuser),
      .cap         (cap)
   );

   asn1t_decode u_decode (
      .cap (cap),
      .dec (dec)
   );

   asn1t_mac u_mac (
      .clock (clock),
      .cmd   (cmd),
      .acc   (acc)
   );

   assign q4 = dec_ff.yp[YEAR_W-1:2];
   assign days_offs = OFFS_W'(q4) - OFFS_W'(q100_ff) + OFFS_W'(q400_ff)
                      + OFFS_W'(dec_ff.doy) + OFFS_W'(dec_ff.day) - DAY_BIAS;

   always_comb begin
      state_in     = state_ff;
      clear        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tlast) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            clear    = 1'b1;
            state_in = dec.ok ? ST_Q100 : ST_DONE;
         end
         ST_Q100: begin
            cmd.en   = 1'b1;
            cmd.a    = $signed(MUL_A_W'(dec_ff.yp));
            cmd.b    = RECIP_100;
            state_in = ST_Q400;
         end
         ST_Q400: begin
            cmd.en   = 1'b1;
            cmd.a    = $signed(MUL_A_W'(q4));
            cmd.b    = RECIP_100;
            state_in = ST_LDQ;
         end
         ST_LDQ: begin
            state_in = ST_DAYS;
         end
         ST_DAYS: begin
            cmd.en   = 1'b1;
            cmd.a    = $signed(MUL_A_W'(dec_ff.yp));
            cmd.b    = DAYS_PER_YEAR;
            cmd.c    = $signed(days_offs);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.en   = 1'b1;
            cmd.a    = acc[MUL_A_W-1:0];
            cmd.b    = SEC_PER_DAY;
            state_in = ST_HR;
         end
         ST_HR: begin
            cmd.en      = 1'b1;
            cmd.use_acc = 1'b1;
            cmd.a       = $signed(MUL_A_W'(dec_ff.hr));
            cmd.b       = SEC_PER_HOUR;
            state_in    = ST_MN;
         end
         ST_MN: begin
            cmd.en      = 1'b1;
            cmd.use_acc = 1'b1;
            cmd.a       = $signed(MUL_A_W'(dec_ff.mn));
            cmd.b       = SEC_PER_MIN;
            state_in    = ST_SEC;
         end
         ST_SEC: begin
            cmd.en      = 1'b1;
            cmd.use_acc = 1'b1;
            cmd.a       = $signed(MUL_A_W'(dec_ff.sec));
            cmd.b       = SEC_ONE;
            state_in    = ST_ZH;
         end
         ST_ZH: begin
            cmd.en      = 1'b1;
            cmd.use_acc = 1'b1;
            cmd.a       = dec_ff.zsub ? -$signed(MUL_A_W'(dec_ff.zh))
                                      : $signed(MUL_A_W'(dec_ff.zh));
            cmd.b       = SEC_PER_HOUR;
            state_in    = ST_ZM;
         end
         ST_ZM: begin
            cmd.en      = 1'b1;
            cmd.use_acc = 1'b1;
            cmd.a       = dec_ff.zsub ? -$signed(MUL_A_W'(dec_ff.zm))
                                      : $signed(MUL_A_W'(dec_ff.zm));
            cmd.b       = SEC_PER_MIN;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         dec_ff <= dec;
      end
      if (state_ff == ST_Q400) begin
         q100_ff <= acc[RECIP_LSB+6:RECIP_LSB];
      end
      if (state_ff == ST_LDQ) begin
         q400_ff <= acc[RECIP_LSB+4:RECIP_LSB];
      end
      if (rsp_load) begin
         rsp_data_ff <= {dec_ff.ok, dec_ff.ok ? acc[EPOCH_W-1:0] : {EPOCH_W{1'b0}}};
      end
   end

   `ASN1T_ASSERT_NEXT(a_last_starts_check, clock, reset, req_xfer && req_tlast, state_ff == ST_CHECK)
   `ASN1T_ASSERT_NEXT(a_check_clears_capture, clock, reset, state_ff == ST_CHECK, cap.t_seen == '0 && !cap.ovf)
   `ASN1T_ASSERT_SAME(a_result_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))
   `ASN1T_ASSERT_SAME(a_invalid_is_zero, clock, reset, rsp_valid_ff && !rsp_data_ff[EPOCH_W], rsp_data_ff[EPOCH_W-1:0] == '0)

endmodule

// ===== tb/sv/asn1_time_checker.sv =====
`timescale 1ns / 1ps
module asn1_time_checker #(
   parameter int MAX_CHARS = asn1t_pkg::MAX_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   input  logic        req_tuser,   // [0] generalized
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [38:0] epoch_seconds, [39] valid_res
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          checked_valid
);
   import asn1t_pkg::*;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic               valid;
   } stamp_result_type;

   stamp_result_type expected_stamps[$];

   logic [7:0] text_buf [MAX_CHARS];
   int         text_len  = 0;
   bit         text_over = 1'b0;
   int         errs      = 0;
   int         pending_q = 0;
   int         n_checked = 0;
   int         n_valid   = 0;

   assign fail_count    = errs;
   assign pending       = pending_q;
   assign checked       = n_checked;
   assign checked_valid = n_valid;

   function automatic int digit_of(input int pos);
      logic [7:0] c;
      if (pos < 0 || pos >= text_len) return -1;
      c = text_buf[pos];
      if (c < CHAR_0 || c > CHAR_9) return -1;
      return int'(c - CHAR_0);
   endfunction

   function automatic bit pair_at(input int pos, output longint v);
      int hi;
      int lo;
      v = 0;
      if (pos < 0) return 1'b0;
      hi = digit_of(pos);
      lo = digit_of(pos + 1);
      if (hi < 0 || lo < 0) return 1'b0;
      v = longint'(hi * 10 + lo);
      return 1'b1;
   endfunction

   function automatic int find_code(input logic [7:0] ch);
      for (int i = 0; i < text_len; i++)
         if (text_buf[i] == ch) return i;
      return -1;
   endfunction

   // days from 1970-01-01 to the first of month m of year y
   function automatic longint days_from_epoch(input longint y, input longint m);
      longint era;
      longint yoe;
      longint doy;
      longint doe;
      if (m <= 2) y = y - 1;
      era = y / 400;
      yoe = y - era * 400;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   function automatic bit decode_stamp(input bit gen, output longint secs);
      int     e;
      int     base;
      longint tz;
      longint zh;
      longint zm;
      longint yh;
      longint yl;
      longint year;
      longint mon;
      longint day;
      longint hr;
      longint mn;
      longint sec;
      longint full;
      secs = 0;
      tz   = 0;
      sec  = 0;
      e = find_code(CHAR_Z);
      if (e < 0) begin
         e = find_code(CHAR_PLUS);
         if (e >= 0) begin
            if (!pair_at(e + 1, zh) || !pair_at(e + 3, zm)) return 1'b0;
            tz = 3600 * zh + 60 * zm;
         end else begin
            e = find_code(CHAR_MINUS);
            if (e < 0) return 1'b0;
            if (!pair_at(e + 1, zh) || !pair_at(e + 3, zm)) return 1'b0;
            tz = -(3600 * zh + 60 * zm);
         end
      end
      if (gen) begin
         if (!pair_at(0, yh) || !pair_at(2, yl)) return 1'b0;
         year = yh * 100 + yl;
         base = 4;
      end else begin
         if (!pair_at(0, year)) return 1'b0;
         base = 2;
      end
      if (!pair_at(base, mon) || !pair_at(base + 2, day) ||
          !pair_at(base + 4, hr) || !pair_at(base + 6, mn)) return 1'b0;
      if (e == (gen ? 14 : 12)) begin
         if (!pair_at(e - 2, sec)) return 1'b0;
      end
      if (year >= 1900) full = year;
      else if (year >= 100) return 1'b0;
      else if (year < 50) full = 2000 + year;
      else full = 1900 + year;
      if (mon < 1 || mon > 12) return 1'b0;
      secs = (days_from_epoch(full, mon) + day - 1) * 86400
             + hr * 3600 + mn * 60 + sec - tz;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      stamp_result_type want;
      longint           secs;
      bit               ok;
      if (reset) begin
         text_len  = 0;
         text_over = 1'b0;
         expected_stamps.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (text_len < MAX_CHARS) begin
               text_buf[text_len] = req_tdata;
               text_len++;
            end else begin
               text_over = 1'b1;
            end
            if (req_tlast) begin
               ok   = 1'b0;
               secs = 0;
               if (!text_over) ok = decode_stamp(req_tuser, secs);
               if (!ok) secs = 0;
               want.epoch = secs[EPOCH_W-1:0];
               want.valid = ok;
               expected_stamps.push_back(want);
               text_len  = 0;
               text_over = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stamps.size() == 0) begin
               $error("result transfer with no string pending: tdata=%h", rsp_tdata);
               errs++;
            end else begin
               want = expected_stamps.pop_front();
               n_checked++;
               if (want.valid) n_valid++;
               if (rsp_tdata[EPOCH_W-1:0] !== want.epoch) begin
                  $error("epoch_seconds: expected %0d, got %0d",
                         $signed(want.epoch), $signed(rsp_tdata[EPOCH_W-1:0]));
                  errs++;
               end
               if (rsp_tdata[EPOCH_W] !== want.valid) begin
                  $error("valid_res: expected %0d, got %0d", want.valid, rsp_tdata[EPOCH_W]);
                  errs++;
               end
            end
         end
      end
      pending_q <= expected_stamps.size();
   end

endmodule

// ===== tb/sv/tb_asn1_time_string_to_epoch.sv =====
`timescale 1ns / 1ps
module tb_asn1_time_string_to_epoch;
   import asn1t_pkg::*;

   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam int         STALL_LIMIT = 5000;
   localparam int         RANDOM_CHARS = 1040;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_code
   logic        req_tlast  = 1'b0;
   logic        req_tuser  = 1'b0;    // [0] generalized
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [38:0] epoch_seconds, [39] valid_res

   int fail_count;
   int pending;
   int checked;
   int checked_valid;

   logic [7:0] str_q[$];
   bit         calm         = 1'b0;
   int         chars_sent   = 0;
   int         strings_sent = 0;
   int         stall_left   = 0;
   int         cycle_cnt    = 0;
   int         quiet_cycles = 0;

   always #2 clock = ~clock;

   asn1_time_string_to_epoch u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   asn1_time_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked       (checked),
      .checked_valid (checked_valid)
   );

   // result side backpressure; every fourth window of the cycle count starts no new stall
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (((cycle_cnt / 256) % 4 == 0) || ($urandom_range(0, 99) < 70)) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                    : $urandom_range(5, 40);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_char(input logic [7:0] c, input bit last, input bit gen);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tuser  <= gen;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // form flag matters only on the last character
   task automatic send_stamp(input bit gen);
      calm = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < str_q.size(); i++) begin
         if (i == str_q.size() - 1) send_char(str_q[i], 1'b1, gen);
         else send_char(str_q[i], 1'b0, 1'($urandom_range(0, 1)));
      end
      chars_sent += str_q.size();
      strings_sent++;
   endtask

   task automatic send_text(input string s, input bit gen);
      str_q.delete();
      for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
      send_stamp(gen);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic void push_pair(input int v);
      str_q.push_back(8'(CHAR_0 + v / 10));
      str_q.push_back(8'(CHAR_0 + v % 10));
   endfunction

   function automatic logic [7:0] pick_term();
      case ($urandom_range(0, 2))
         0:       return CHAR_Z;
         1:       return CHAR_PLUS;
         default: return CHAR_MINUS;
      endcase
   endfunction

   function automatic int pick_field(input int lo, input int hi);
      if ($urandom_range(0, 11) == 0) return $urandom_range(0, 99);
      return $urandom_range(lo, hi);
   endfunction

   function automatic bit make_stamp();
      bit         gen;
      int         len;
      int         r;
      logic [7:0] t;
      gen = 1'($urandom_range(0, 1));
      str_q.delete();
      if ($urandom_range(0, 99) < 12) begin
         len = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
         repeat (len) begin
            r = $urandom_range(0, 3);
            if (r == 1) str_q.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
            else if (r == 2) str_q.push_back(pick_term());
            else str_q.push_back(8'($urandom_range(0, 255)));
         end
         return gen;
      end
      if (gen) begin
         r = $urandom_range(0, 9);
         if (r < 6) len = $urandom_range(1950, 2099);
         else if (r < 8) len = $urandom_range(0, 9999);
         else len = $urandom_range(0, 99);
         push_pair(len / 100);
         push_pair(len % 100);
      end else begin
         push_pair($urandom_range(0, 99));
      end
      push_pair(pick_field(1, 12));
      push_pair(pick_field(1, 31));
      push_pair(pick_field(0, 23));
      push_pair(pick_field(0, 59));
      if ($urandom_range(0, 1)) push_pair(pick_field(0, 59));
      if ($urandom_range(0, 7) == 0) begin
         str_q.push_back(CHAR_DOT);
         repeat ($urandom_range(1, 3)) str_q.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
      end
      t = pick_term();
      str_q.push_back(t);
      if (t != CHAR_Z) begin
         push_pair(pick_field(0, 14));
         push_pair(pick_field(0, 59));
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 20)) str_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0)
         str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0)
         repeat ($urandom_range(1, 4)) if (str_q.size() > 1) void'(str_q.pop_back());
      return gen;
   endfunction

   initial begin
      int  random_chars;
      int  before_cnt;
      bit  gen;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_text("991231235959Z", 1'b0);
      send_text("000101000000Z", 1'b0);
      send_text("490101000000Z", 1'b0);
      send_text("500101000000Z", 1'b0);
      send_text("19700101000000Z", 1'b1);
      send_text("99991231235959Z", 1'b1);
      send_text("19000101000000Z", 1'b1);
      send_text("18991231235959Z", 1'b1);
      send_text("00490229120000Z", 1'b1);
      send_text("2402291200+0530", 1'b0);
      send_text("240229120000-9999", 1'b0);
      send_text("991299999999Z", 1'b0);
      send_text("991301000000Z", 1'b0);
      send_text("990001000000Z", 1'b0);
      send_text("9901010000", 1'b0);
      send_text("99 101000000Z", 1'b0);
      send_text("99010100000Z", 1'b0);
      send_text("9901010000+05", 1'b0);
      send_text("990101000000-0100+0200", 1'b0);
      send_text("990101000000+0100Z", 1'b0);
      send_text("-9901010000", 1'b0);
      send_text("20240101000000ZABCDEFGHIJKLMNOPQ", 1'b1);
      drain_results();
      send_text("20240101000000ZABCDEFGHIJKLMNOPQR", 1'b1);
      send_text("Z", 1'b1);

      random_chars = 0;
      while (random_chars < RANDOM_CHARS) begin
         gen = make_stamp();
         before_cnt = chars_sent;
         send_stamp(gen);
         random_chars += chars_sent - before_cnt;
         if (strings_sent % 16 == 0) drain_results();
      end

      drain_results();
      repeat (30) @(posedge clock);
      $display("Sent %0d time strings, %0d characters; %0d results checked, %0d of them valid.",
               strings_sent, chars_sent, checked, checked_valid);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
